// ----- src/cv2d_pkg.sv -----
// Package with the types, constants and register codes of the 2D convolution core.
package cv2d_pkg;

    localparam int MAX_KERNEL = 7;
    localparam int MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int LINE_ROWS = MAX_KERNEL - 1;
    localparam int KERN_CELLS = MAX_KERNEL * MAX_KERNEL;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int SLOT_W = $clog2(LINE_ROWS);
    localparam int DIM_W = 11;
    localparam int KSIZE_W = 3;
    localparam int PROD_W = 25;
    localparam int ROWSUM_W = 28;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_COEF = 1'b1;

    typedef enum logic [1:0] {
        REG_KERNEL = 2'd0,
        REG_WIDTH = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic cmd;
        logic [7:0] pixel;
        logic [5:0] coef_index;
        logic signed [15:0] coef_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] filtered;
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic frame_end;
    } t_out_item;

endpackage

// ----- src/cv2d_linebuf.sv -----
// Line store holding the previous kernel rows, one memory per row slot.
module cv2d_linebuf (
    input  logic i_clk,
    input  logic i_rd_en,
    input  logic i_wr_en,
    input  logic [cv2d_pkg::SLOT_W-1:0] i_slot,
    input  logic [cv2d_pkg::COL_W-1:0] i_col,
    input  logic [7:0] i_pixel,
    output logic [cv2d_pkg::LINE_ROWS-1:0][7:0] o_rd_data
);
    import cv2d_pkg::*;

    logic [7:0] r_mem [LINE_ROWS][MAX_WIDTH];
    logic [LINE_ROWS-1:0][7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        for (int m = 0; m < LINE_ROWS; m++) begin
            if (i_rd_en) begin
                r_rd_data[m] <= r_mem[m][i_col];
            end
            if (i_wr_en && (i_slot == SLOT_W'(m))) begin
                r_mem[m][i_col] <= i_pixel;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/convolution_2d_valid_core.sv -----
// Top level of the streaming valid-region 2D convolution core.
// One item is taken per clock when the output side keeps up. The item and its line store
// read are registered at the transfer edge, and the product, row adder and final adder
// stages follow. The line store is not cleared after reset.
module convolution_2d_valid_core (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  cv2d_pkg::t_in_item i_data,
    output logic o_valid,
    input  logic i_ready,
    output cv2d_pkg::t_out_item o_data,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [3:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    import cv2d_pkg::*;

    typedef struct packed {
        logic is_coef;
        logic [7:0] pixel;
        logic [5:0] coef_index;
        logic signed [15:0] coef_value;
        logic produce;
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic frame_end;
        logic [SLOT_W-1:0] slot;
    } t_s1;

    typedef struct packed {
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic frame_end;
    } t_pos;

    logic [KSIZE_W-1:0] r_ksize;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [SLOT_W-1:0] r_slot;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] n_col;
    logic [SLOT_W-1:0] n_slot;

    logic [DIM_W-1:0] w_w;
    logic [DIM_W-1:0] w_h;
    logic [KSIZE_W-1:0] w_k;
    logic w_acc;
    logic w_produce;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    t_s1 r_s1;
    t_pos r_pos2, r_pos3;
    t_out_item r_out;

    logic [LINE_ROWS-1:0][7:0] w_rd_data;
    logic [7:0] r_window [MAX_KERNEL][MAX_KERNEL];
    logic [7:0] n_window [MAX_KERNEL][MAX_KERNEL];
    logic signed [15:0] r_coef [KERN_CELLS];
    logic signed [15:0] w_csel [MAX_KERNEL][MAX_KERNEL];
    logic signed [PROD_W-1:0] r_prod [MAX_KERNEL][MAX_KERNEL];
    logic signed [ROWSUM_W-1:0] r_rowsum [MAX_KERNEL];
    logic signed [ROWSUM_W-1:0] n_rowsum [MAX_KERNEL];
    logic signed [31:0] n_total;
    logic w_mv1;
    logic w_cfg_wr;

    // Configuration port.
    assign pready = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ksize <= KSIZE_W'(3);
            r_width <= DIM_W'(1024);
            r_height <= DIM_W'(1024);
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_KERNEL: r_ksize <= pwdata[KSIZE_W-1:0];
                REG_WIDTH: r_width <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_KERNEL: prdata = 32'(r_ksize);
            REG_WIDTH: prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            default: prdata = '0;
        endcase
    end

    always_comb begin
        if (r_width == '0) begin
            w_w = DIM_W'(1);
        end else if (r_width > DIM_W'(MAX_WIDTH)) begin
            w_w = DIM_W'(MAX_WIDTH);
        end else begin
            w_w = r_width;
        end
        if (r_height == '0) begin
            w_h = DIM_W'(1);
        end else if (r_height > DIM_W'(MAX_HEIGHT)) begin
            w_h = DIM_W'(MAX_HEIGHT);
        end else begin
            w_h = r_height;
        end
        w_k = r_ksize | KSIZE_W'(1);
    end

    // Handshake chain.
    assign w_rdy4 = !r_v4 || i_ready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign w_acc = i_valid && w_rdy1;
    assign w_mv1 = r_v1 && w_rdy2;

    // Raster position.
    always_comb begin
        logic [DIM_W-1:0] c_inc;
        logic [DIM_W-1:0] r_inc;
        c_inc = DIM_W'(r_col) + DIM_W'(1);
        r_inc = DIM_W'(r_row) + DIM_W'(1);
        n_col = c_inc[COL_W-1:0];
        n_row = r_row;
        n_slot = r_slot;
        if (c_inc >= w_w) begin
            n_col = '0;
            if (r_inc >= w_h) begin
                n_row = '0;
                n_slot = '0;
            end else begin
                n_row = r_inc[ROW_W-1:0];
                n_slot = (r_slot == SLOT_W'(LINE_ROWS - 1)) ? '0 : r_slot + SLOT_W'(1);
            end
        end else if (DIM_W'(r_row) >= w_h) begin
            n_row = '0;
            n_slot = '0;
        end
    end

    assign w_produce = (DIM_W'(r_row) < w_h) && (DIM_W'(r_col) < w_w)
        && (DIM_W'(r_row) + DIM_W'(1) >= DIM_W'(w_k))
        && (DIM_W'(r_col) + DIM_W'(1) >= DIM_W'(w_k));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_slot <= '0;
        end else if (w_acc && (i_data.cmd == CMD_PIXEL)) begin
            r_row <= n_row;
            r_col <= n_col;
            r_slot <= n_slot;
        end
    end

    cv2d_linebuf u_linebuf (
        .i_clk(i_clk),
        .i_rd_en(w_acc),
        .i_wr_en(w_acc && (i_data.cmd == CMD_PIXEL)),
        .i_slot(r_slot),
        .i_col(r_col),
        .i_pixel(i_data.pixel),
        .o_rd_data(w_rd_data)
    );

    // Stage one: item and line store read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1.is_coef <= (i_data.cmd == CMD_COEF);
            r_s1.pixel <= i_data.pixel;
            r_s1.coef_index <= i_data.coef_index;
            r_s1.coef_value <= i_data.coef_value;
            r_s1.produce <= w_produce && (i_data.cmd == CMD_PIXEL);
            r_s1.out_row <= 10'(r_row - ROW_W'(w_k - KSIZE_W'(1)));
            r_s1.out_col <= 10'(r_col - COL_W'(w_k - KSIZE_W'(1)));
            r_s1.frame_end <= (DIM_W'(r_row) == w_h - DIM_W'(1))
                && (DIM_W'(r_col) == w_w - DIM_W'(1));
            r_s1.slot <= r_slot;
        end
    end

    // Window shift.
    always_comb begin
        logic [SLOT_W:0] m;
        for (int a = 0; a < MAX_KERNEL; a++) begin
            for (int b = 0; b < MAX_KERNEL - 1; b++) begin
                n_window[a][b] = r_window[a][b + 1];
            end
        end
        n_window[MAX_KERNEL - 1][MAX_KERNEL - 1] = r_s1.pixel;
        for (int a = 0; a < LINE_ROWS; a++) begin
            m = {1'b0, r_s1.slot} + (SLOT_W + 1)'(a);
            if (m >= (SLOT_W + 1)'(LINE_ROWS)) begin
                m = m - (SLOT_W + 1)'(LINE_ROWS);
            end
            n_window[a][MAX_KERNEL - 1] = w_rd_data[m[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < MAX_KERNEL; a++) begin
                for (int b = 0; b < MAX_KERNEL; b++) begin
                    r_window[a][b] <= '0;
                end
            end
            for (int i = 0; i < KERN_CELLS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (w_mv1) begin
            if (!r_s1.is_coef) begin
                r_window <= n_window;
            end else if (r_s1.coef_index < 6'(KERN_CELLS)) begin
                r_coef[r_s1.coef_index] <= r_s1.coef_value;
            end
        end
    end

    // Coefficient placement for the active kernel size.
    for (genvar a = 0; a < MAX_KERNEL; a++) begin : g_row
        for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_col
            localparam int O1 = MAX_KERNEL - 1;
            localparam int O3 = MAX_KERNEL - 3;
            localparam int O5 = MAX_KERNEL - 5;
            localparam int O7 = MAX_KERNEL - 7;
            localparam bit E1 = (a >= O1) && (b >= O1);
            localparam bit E3 = (O3 >= 0) && (a >= O3) && (b >= O3);
            localparam bit E5 = (O5 >= 0) && (a >= O5) && (b >= O5);
            localparam bit E7 = (O7 >= 0) && (a >= O7) && (b >= O7);
            localparam int I1 = E1 ? (a - O1) * MAX_KERNEL + (b - O1) : 0;
            localparam int I3 = E3 ? (a - O3) * MAX_KERNEL + (b - O3) : 0;
            localparam int I5 = E5 ? (a - O5) * MAX_KERNEL + (b - O5) : 0;
            localparam int I7 = E7 ? (a - O7) * MAX_KERNEL + (b - O7) : 0;
            always_comb begin
                case (w_k)
                    3'd1: w_csel[a][b] = E1 ? r_coef[I1] : '0;
                    3'd3: w_csel[a][b] = E3 ? r_coef[I3] : '0;
                    3'd5: w_csel[a][b] = E5 ? r_coef[I5] : '0;
                    3'd7: w_csel[a][b] = E7 ? r_coef[I7] : '0;
                    default: w_csel[a][b] = '0;
                endcase
            end
            always_ff @(posedge i_clk) begin
                if (w_rdy2) begin
                    r_prod[a][b] <= $signed({1'b0, n_window[a][b]}) * w_csel[a][b];
                end
            end
        end
    end

    // Stage two: products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1 && r_s1.produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_pos2 <= '{out_row: r_s1.out_row, out_col: r_s1.out_col,
                        frame_end: r_s1.frame_end};
        end
    end

    // Stage three: row sums.
    always_comb begin
        for (int a = 0; a < MAX_KERNEL; a++) begin
            n_rowsum[a] = '0;
            for (int b = 0; b < MAX_KERNEL; b++) begin
                n_rowsum[a] = n_rowsum[a] + ROWSUM_W'(r_prod[a][b]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_rowsum <= n_rowsum;
            r_pos3 <= r_pos2;
        end
    end

    // Stage four: total and output register.
    always_comb begin
        n_total = '0;
        for (int a = 0; a < MAX_KERNEL; a++) begin
            n_total = n_total + 32'(r_rowsum[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_rdy4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_out.filtered <= n_total;
            r_out.out_row <= r_pos3.out_row;
            r_out.out_col <= r_pos3.out_col;
            r_out.frame_end <= r_pos3.frame_end;
        end
    end

    assign o_valid = r_v4;
    assign o_data = r_out;

    // The row slot always names one of the line store rows.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(LINE_ROWS - 1))
        else $error("line store slot out of range");

    // A product stage entry only ever comes from a first stage entry.
    a_v2_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v2) |-> $past(r_v1))
        else $error("product stage filled without a source");

    // An empty first stage never holds off the input.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> o_ready)
        else $error("input stalled with an empty first stage");

endmodule
